// ===== hdl/message_admission_filter_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for message_admission_filter
// Short forms for clocked assertions with an active low reset disable.
// ---------------------------------------------------------------------------
`ifndef MESSAGE_ADMISSION_FILTER_MACROS_SVH
`define MESSAGE_ADMISSION_FILTER_MACROS_SVH

// Same-cycle implication on clk_i, disabled while rst_ni is low
`define MAF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk_i, disabled while rst_ni is low
`define MAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/maf_pkg.sv =====
// ---------------------------------------------------------------------------
// maf_pkg
// Shared widths, codes and transaction types of the message admission filter.
// ---------------------------------------------------------------------------
package maf_pkg;

  // Depth of the ring of recently accepted signatures
  localparam int unsigned RecentDepth = 8;
  localparam int unsigned RecentIdxW  = (RecentDepth > 1) ? $clog2(RecentDepth) : 1;

  localparam int unsigned SigW     = 64;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned TokW     = 8;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned CountW   = 32;
  localparam int unsigned ReasonW  = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Drop reason codes
  localparam logic [ReasonW-1:0] ReasonOk       = 3'd0;
  localparam logic [ReasonW-1:0] ReasonNotReady = 3'd1;
  localparam logic [ReasonW-1:0] ReasonRepeat   = 3'd2;
  localparam logic [ReasonW-1:0] ReasonRate     = 3'd3;
  localparam logic [ReasonW-1:0] ReasonQueue    = 3'd4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgStoreReady = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBurst      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPeriod     = 2'd2;

  // Reset values of the configuration
  localparam logic [TokW-1:0]    BurstReset  = 8'd4;
  localparam logic [PeriodW-1:0] PeriodReset = 16'd60000;

  // Classified item from the front to the back
  typedef struct packed {
    logic [SigW-1:0]    sig;
    logic [TimeW-1:0]   now;
    logic               qfull;
    logic [ReasonW-1:0] reason;  // ReasonOk when the front checks passed
  } cmd_t;

  // Status returned from the back to the front
  typedef struct packed {
    logic            done;    // item finished, result written
    logic            commit;  // item admitted, record its signature
    logic [SigW-1:0] sig;
  } back_stat_t;

  // One result transaction
  typedef struct packed {
    logic               accepted;
    logic [ReasonW-1:0] reason;
    logic [CountW-1:0]  drops;
    logic [TokW-1:0]    tokens;
  } result_t;

endpackage

// ===== hdl/message_admission_filter.sv =====
// Path from push to result: through the bucket refill divider and token use,
// straight to token use with a zero refill period, or straight to the result
// for a not-ready or repeat drop. Only one item is in flight; a new arrival is
// taken once the last one is finished. Reset (rst_ni low, async) empties both
// queues, loads the bucket with 4 tokens, clears the ring, refill time and
// drop counter, and restores configuration defaults.
// ---------------------------------------------------------------------------
// message_admission_filter
// Admission filter: readiness, repeat filter, token bucket and queue check.
// ---------------------------------------------------------------------------
module message_admission_filter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // arrival queue side
  input  logic                           push,
  output logic                           full,
  input  logic [maf_pkg::SigW-1:0]       signature_i,
  input  logic [maf_pkg::TimeW-1:0]      now_ms_i,
  input  logic                           queue_full_i,
  // result queue side
  output logic                           empty,
  input  logic                           pop,
  output logic                           accepted_o,
  output logic [maf_pkg::ReasonW-1:0]    drop_reason_o,
  output logic [maf_pkg::CountW-1:0]     drop_count_o,
  output logic [maf_pkg::TokW-1:0]       tokens_left_o,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [maf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [maf_pkg::CfgDataW-1:0]   cfg_data_i
);
  import maf_pkg::*;

  logic               store_ready_q;
  logic [TokW-1:0]    burst_q;
  logic [PeriodW-1:0] period_q;
  logic               cfg_wr;

  logic               cmd_valid, cmd_ready;
  cmd_t               cmd;
  back_stat_t         stat;
  logic               res_wr, res_full;
  result_t            res_wdata, res_rdata;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_ready_q <= 1'b0;
      burst_q       <= BurstReset;
      period_q      <= PeriodReset;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        CfgStoreReady: store_ready_q <= cfg_data_i[0];
        CfgBurst:      burst_q       <= cfg_data_i[TokW-1:0];
        CfgPeriod:     period_q      <= cfg_data_i[PeriodW-1:0];
        default: begin
        end
      endcase
    end
  end

  maf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .signature_i   (signature_i),
    .now_ms_i      (now_ms_i),
    .queue_full_i  (queue_full_i),
    .store_ready_i (store_ready_q),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd),
    .stat_i        (stat)
  );

  maf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .burst_i     (burst_q),
    .period_i    (period_q),
    .res_full_i  (res_full),
    .res_wr_o    (res_wr),
    .res_o       (res_wdata),
    .stat_o      (stat)
  );

  maf_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_wr),
    .wdata_i (res_wdata),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .rdata_o (res_rdata)
  );

  assign accepted_o    = res_rdata.accepted;
  assign drop_reason_o = res_rdata.reason;
  assign drop_count_o  = res_rdata.drops;
  assign tokens_left_o = res_rdata.tokens;

endmodule

// ===== hdl/maf_div.sv =====
// ---------------------------------------------------------------------------
// maf_div
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit
// per cycle.
// ---------------------------------------------------------------------------
module maf_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [maf_pkg::TimeW-1:0]    dividend_i,
  input  logic [maf_pkg::PeriodW-1:0]  divisor_i,
  output logic                         done_o,
  output logic [maf_pkg::TimeW-1:0]    quot_o
);
  import maf_pkg::*;

  localparam int unsigned CntW = $clog2(TimeW);
  localparam logic [CntW-1:0] LastStep = CntW'(TimeW - 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [PeriodW-1:0]  rem_q, rem_d;
  logic [PeriodW-1:0]  dvs_q, dvs_d;
  logic [TimeW-1:0]    quo_q, quo_d;
  logic [PeriodW:0]    trial;
  logic [PeriodW:0]    diff;
  logic                ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, quo_q[TimeW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[PeriodW-1:0] : trial[PeriodW-1:0];
      quo_d = {quo_q[TimeW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Advance the datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== hdl/maf_front.sv =====
// ---------------------------------------------------------------------------
// maf_front
// Accepts arrivals, checks store readiness and repeats against the ring of
// recent signatures, and queues the classified item for the back.
// ---------------------------------------------------------------------------
module maf_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [maf_pkg::SigW-1:0]    signature_i,
  input  logic [maf_pkg::TimeW-1:0]   now_ms_i,
  input  logic                        queue_full_i,
  input  logic                        store_ready_i,
  output logic                        cmd_valid_o,
  input  logic                        cmd_ready_i,
  output maf_pkg::cmd_t               cmd_o,
  input  maf_pkg::back_stat_t         stat_i
);
  import maf_pkg::*;

  localparam int unsigned QDepth = 2;
  localparam logic [RecentIdxW-1:0] LastIdx = RecentIdxW'(RecentDepth - 1);

  logic                   busy_q;
  logic                   in_vld_q;
  logic [SigW-1:0]        in_sig_q;
  logic [TimeW-1:0]       in_now_q;
  logic                   in_qfull_q;
  logic                   take;

  logic [SigW-1:0]        ring_q [RecentDepth];
  logic [RecentDepth-1:0] ring_vld_q;
  logic [RecentIdxW-1:0]  widx_q;
  logic [RecentDepth-1:0] hit;
  logic                   repeat_hit;
  cmd_t                   cls;

  cmd_t                   cq_q [QDepth];
  logic                   cq_wptr_q, cq_rptr_q;
  logic [1:0]             cq_cnt_q;
  logic                   cq_push, cq_pop;

  // One item in flight from acceptance until the back reports it done
  assign take   = push_i && !busy_q;
  assign full_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      in_vld_q <= 1'b0;
    end else begin
      if (take) begin
        busy_q <= 1'b1;
      end else if (stat_i.done) begin
        busy_q <= 1'b0;
      end
      if (take) begin
        in_vld_q <= 1'b1;
      end else if (cq_push) begin
        in_vld_q <= 1'b0;
      end
    end
  end

  // Capture the arriving transaction
  always_ff @(posedge clk_i) begin
    if (take) begin
      in_sig_q   <= signature_i;
      in_now_q   <= now_ms_i;
      in_qfull_q <= queue_full_i;
    end
  end

  // Compare against every recorded signature in parallel
  always_comb begin
    for (int i = 0; i < RecentDepth; i++) begin
      hit[i] = ring_vld_q[i] && (ring_q[i] == in_sig_q);
    end
  end
  assign repeat_hit = (|hit) && (in_sig_q != '0);

  // Classify the item
  always_comb begin
    cls.sig   = in_sig_q;
    cls.now   = in_now_q;
    cls.qfull = in_qfull_q;
    if (!store_ready_i) begin
      cls.reason = ReasonNotReady;
    end else if (repeat_hit) begin
      cls.reason = ReasonRepeat;
    end else begin
      cls.reason = ReasonOk;
    end
  end

  // Record admitted signatures
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_vld_q <= '0;
      widx_q     <= '0;
    end else if (stat_i.commit) begin
      ring_vld_q[widx_q] <= 1'b1;
      widx_q <= (widx_q == LastIdx) ? '0 : widx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat_i.commit) begin
      ring_q[widx_q] <= stat_i.sig;
    end
  end

  // Command queue toward the back
  assign cq_push     = in_vld_q && (cq_cnt_q != 2'(QDepth));
  assign cq_pop      = cmd_ready_i && (cq_cnt_q != 2'd0);
  assign cmd_valid_o = cq_cnt_q != 2'd0;
  assign cmd_o       = cq_q[cq_rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cq_wptr_q <= 1'b0;
      cq_rptr_q <= 1'b0;
      cq_cnt_q  <= 2'd0;
    end else begin
      if (cq_push) begin
        cq_wptr_q <= ~cq_wptr_q;
      end
      if (cq_pop) begin
        cq_rptr_q <= ~cq_rptr_q;
      end
      if (cq_push && !cq_pop) begin
        cq_cnt_q <= cq_cnt_q + 2'd1;
      end else if (cq_pop && !cq_push) begin
        cq_cnt_q <= cq_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cq_push) begin
      cq_q[cq_wptr_q] <= cls;
    end
  end

endmodule

// ===== hdl/maf_resq.sv =====
// ---------------------------------------------------------------------------
// maf_resq
// Two-entry result queue between the back and the result ports.
// ---------------------------------------------------------------------------
module maf_resq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  maf_pkg::result_t  wdata_i,
  output logic              full_o,
  output logic              empty_o,
  input  logic              pop_i,
  output maf_pkg::result_t  rdata_o
);
  import maf_pkg::*;

  localparam int unsigned QDepth = 2;

  result_t    mem_q [QDepth];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_pop;

  assign full_o  = cnt_q == 2'(QDepth);
  assign empty_o = cnt_q == 2'd0;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr_i) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
      if (wr_i && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !wr_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/maf_back.sv =====
// ---------------------------------------------------------------------------
// maf_back
// Carries out classified items: token bucket refill through the divider,
// token use, drop counting and result generation.
// ---------------------------------------------------------------------------
module maf_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  maf_pkg::cmd_t                 cmd_i,
  input  logic [maf_pkg::TokW-1:0]      burst_i,
  input  logic [maf_pkg::PeriodW-1:0]   period_i,
  input  logic                          res_full_i,
  output logic                          res_wr_o,
  output maf_pkg::result_t              res_o,
  output maf_pkg::back_stat_t           stat_o
);
  import maf_pkg::*;

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SDiv    = 3'd1;
  localparam logic [2:0] SMul    = 3'd2;
  localparam logic [2:0] SRefill = 3'd3;
  localparam logic [2:0] STake   = 3'd4;
  localparam logic [2:0] SFin    = 3'd5;

  logic [2:0]                 state_q;
  cmd_t                       cmd_q;
  logic [ReasonW-1:0]         reason_q;
  logic [TokW-1:0]            tok_q;
  logic [TimeW-1:0]           last_q;
  logic [CountW-1:0]          drop_q;
  logic [TimeW-1:0]           due_q;
  logic [TimeW-1:0]           prod_q;

  logic                       take;
  logic                       div_start;
  logic                       div_done;
  logic [TimeW-1:0]           div_quot;
  logic [TimeW-1:0]           elapsed;
  logic [TimeW+PeriodW-1:0]   prod_full;
  logic [TimeW:0]             tok_sum;
  logic [TokW-1:0]            tok_refilled;
  logic [CountW-1:0]          drop_next;

  assign cmd_ready_o = (state_q == SIdle) && !res_full_i;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign div_start   = take && (cmd_i.reason == ReasonOk) && (period_i != '0);
  assign elapsed     = cmd_i.now - last_q;

  maf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (elapsed),
    .divisor_i  (period_i),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Refill arithmetic: periods due times period, saturating token add
  assign prod_full    = due_q * period_i;
  assign tok_sum      = {{(TimeW + 1 - TokW){1'b0}}, tok_q} + {1'b0, due_q};
  assign tok_refilled = (tok_sum > {{(TimeW + 1 - TokW){1'b0}}, burst_i}) ? burst_i
                                                                           : tok_sum[TokW-1:0];
  assign drop_next    = (reason_q != ReasonOk) ? drop_q + 1'b1 : drop_q;

  // Sequence one item through refill, token use and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      tok_q   <= BurstReset;
      last_q  <= '0;
      drop_q  <= '0;
    end else begin
      case (state_q)
        SIdle: begin
          if (take) begin
            if (cmd_i.reason != ReasonOk) begin
              state_q <= SFin;
            end else if (period_i == '0) begin
              state_q <= STake;
            end else begin
              state_q <= SDiv;
            end
          end
        end
        SDiv: begin
          if (div_done) begin
            state_q <= SMul;
          end
        end
        SMul: begin
          state_q <= SRefill;
        end
        SRefill: begin
          if (due_q != '0) begin
            tok_q  <= tok_refilled;
            last_q <= last_q + prod_q;
          end
          state_q <= STake;
        end
        STake: begin
          if (tok_q != '0) begin
            tok_q <= tok_q - 1'b1;
          end
          state_q <= SFin;
        end
        SFin: begin
          drop_q  <= drop_next;
          state_q <= SIdle;
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  // Datapath registers of the item at work
  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q    <= cmd_i;
      reason_q <= cmd_i.reason;
    end
    if (state_q == SDiv && div_done) begin
      due_q <= div_quot;
    end
    if (state_q == SMul) begin
      prod_q <= prod_full[TimeW-1:0];
    end
    if (state_q == STake) begin
      if (tok_q == '0) begin
        reason_q <= ReasonRate;
      end else if (cmd_q.qfull) begin
        reason_q <= ReasonQueue;
      end else begin
        reason_q <= ReasonOk;
      end
    end
  end

  // Write the result and report back to the front
  assign res_wr_o        = state_q == SFin;
  assign res_o.accepted  = reason_q == ReasonOk;
  assign res_o.reason    = reason_q;
  assign res_o.drops     = drop_next;
  assign res_o.tokens    = tok_q;
  assign stat_o.done     = state_q == SFin;
  assign stat_o.commit   = (state_q == SFin) && (reason_q == ReasonOk);
  assign stat_o.sig      = cmd_q.sig;

endmodule

// ===== hdl/maf_checker.sv =====
// ---------------------------------------------------------------------------
// maf_checker
// Port-level checks of the message admission filter, bound to the top level.
// ---------------------------------------------------------------------------
`include "message_admission_filter_macros.svh"

module maf_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  input  logic                           full,
  input  logic                           empty,
  input  logic                           pop,
  input  logic                           accepted_o,
  input  logic [maf_pkg::ReasonW-1:0]    drop_reason_o,
  input  logic [maf_pkg::CountW-1:0]     drop_count_o
);
  import maf_pkg::*;

  logic acc_match;
  logic res_wait;

  assign acc_match = accepted_o == (drop_reason_o == ReasonOk);
  assign res_wait  = !empty && !pop;

  // A taken arrival raises full to close the input side
  `MAF_ASSERT_NEXT(a_push_closes, push && !full, full, "arrival accepted but full not raised")

  // The admitted flag agrees with the reason code
  `MAF_ASSERT_NOW(a_accept_reason, !empty, acc_match, "accepted flag disagrees with reason")

  // Only defined reason codes appear
  `MAF_ASSERT_NOW(a_reason_range, !empty, drop_reason_o <= ReasonQueue, "undefined reason code")

  // A waiting result that is not taken stays in place
  `MAF_ASSERT_NEXT(a_res_hold, res_wait, !empty && $stable(drop_count_o), "result moved")

endmodule

bind message_admission_filter maf_checker u_maf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .push          (push),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .accepted_o    (accepted_o),
  .drop_reason_o (drop_reason_o),
  .drop_count_o  (drop_count_o)
);
